[rtl/core/utbl_pkg.sv]
// Shared types and codes for the unique-key row table.
package utbl_pkg;

    // Fixed port geometry
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int SLOT_W    = 6;
    localparam int COLUMN_W  = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int ROWS_W    = 7;
    localparam int CFG_W     = 4;

    // Operation kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_SELECT = 2'd3
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_DUP_KEY   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_BAD_SLOT  = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // Configuration register indexes
    localparam logic CFG_KEY_COLUMN   = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Write strobes from the sequencer to the row store
    typedef struct packed {
        logic cell_we;
        logic used_we;
        logic used_wdata;
    } mem_ctl_t;

    // Result hand-off from the sequencer to the output register
    typedef struct packed {
        logic    load;
        status_t status;
    } res_t;

endpackage

[rtl/core/utbl_store.sv]
// Row store: cell memory and per-row used flags, single address, registered read.
module utbl_store
    import utbl_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 8
) (
    input  logic                 aclk,
    input  logic [$clog2(ROWS)-1:0] row,
    input  logic [((COLS > 1) ? $clog2(COLS) : 1)-1:0] col,
    input  mem_ctl_t             ctl,
    input  logic [VALUE_W-1:0]   wdata,
    output logic [VALUE_W-1:0]   cell_q,
    output logic                 used_q
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int DEPTH = ROWS * (1 << CW);

    logic [VALUE_W-1:0] cell_mem [DEPTH];
    logic               used_mem [ROWS];
    logic [RW+CW-1:0]   cell_addr;

    assign cell_addr = {row, col};

    always_ff @(posedge aclk) begin
        if (ctl.cell_we) begin
            cell_mem[cell_addr] <= wdata;
        end
        cell_q <= cell_mem[cell_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.used_we) begin
            used_mem[row] <= ctl.used_wdata;
        end
        used_q <= used_mem[row];
    end

endmodule

[rtl/core/utbl_stage.sv]
// Staging row: collects the column words of an insert run.
module utbl_stage
    import utbl_pkg::*;
#(
    parameter int COLS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [VALUE_W-1:0]   push_data,
    input  logic                 clear,
    input  logic [((COLS > 1) ? $clog2(COLS) : 1)-1:0] rd_idx,
    output logic [VALUE_W-1:0]   rd_data,
    output logic [$clog2(COLS+1)-1:0] cnt
);

    localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CCW = $clog2(COLS + 1);

    logic [VALUE_W-1:0] stage_reg [COLS];
    logic [CCW-1:0]     cnt_reg;
    logic [CCW-1:0]     cnt_next;
    logic               room;

    assign room    = 32'(cnt_reg) < COLS;
    assign rd_data = stage_reg[rd_idx];
    assign cnt     = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (clear) begin
            cnt_next = '0;
        end else if (push && room) begin
            cnt_next = cnt_reg + CCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Extra words beyond the row width are dropped
    always_ff @(posedge aclk) begin
        if (push && room) begin
            stage_reg[CW'(cnt_reg)] <= push_data;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= COLS)
        else $error("staging count beyond row width");

endmodule

[rtl/core/utbl_seq.sv]
// Sequencer: row scan with shared equality compare, row write-back and result codes.
module utbl_seq
    import utbl_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_acc,
    input  logic [1:0]           in_kind,
    input  logic [SLOT_W-1:0]    in_slot,
    input  logic [COLUMN_W-1:0]  in_col,
    input  logic [VALUE_W-1:0]   in_val,
    input  logic                 in_last,
    input  logic [CFG_W-1:0]     key_col,
    input  logic [CFG_W-1:0]     col_cnt,
    input  logic                 out_free,
    output logic                 idle,
    input  logic [$clog2(COLS+1)-1:0] stg_cnt,
    input  logic [VALUE_W-1:0]   stg_rd_data,
    output logic [((COLS > 1) ? $clog2(COLS) : 1)-1:0] stg_rd_idx,
    output logic                 stg_push,
    output logic                 stg_clear,
    output logic [$clog2(ROWS)-1:0] mem_row,
    output logic [((COLS > 1) ? $clog2(COLS) : 1)-1:0] mem_col,
    output mem_ctl_t             mem_ctl,
    output logic [VALUE_W-1:0]   mem_wdata,
    input  logic [VALUE_W-1:0]   cell_q,
    input  logic                 used_q,
    output res_t                 res,
    output logic [$clog2(ROWS)-1:0] res_slot,
    output logic [$clog2(ROWS+1)-1:0] rows_used
);

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CCW = $clog2(COLS + 1);
    localparam int HW  = $clog2(ROWS + 1);

    typedef enum logic [6:0] {
        SQ_IDLE    = 7'b0000001,
        SQ_INS_KEY = 7'b0000010,
        SQ_SCAN    = 7'b0000100,
        SQ_WRITE   = 7'b0001000,
        SQ_RD      = 7'b0010000,
        SQ_CHK     = 7'b0100000,
        SQ_DONE    = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [HW-1:0]       hwm_reg, hwm_next;
    logic [HW-1:0]       used_count_reg, used_count_next;
    logic                pend_valid_reg, pend_valid_next;

    logic [HW-1:0]       issue_reg, issue_next;
    logic [RW-1:0]       pend_row_reg, pend_row_next;
    logic                free_found_reg, free_found_next;
    logic [RW-1:0]       free_row_reg, free_row_next;
    logic [RW-1:0]       ins_row_reg, ins_row_next;
    logic                fresh_reg, fresh_next;
    logic [CW-1:0]       wcol_reg, wcol_next;
    logic [CW-1:0]       scan_col_reg, scan_col_next;
    logic [CCW-1:0]      snap_reg, snap_next;
    logic [VALUE_W-1:0]  cmp_val_reg, cmp_val_next;
    logic                chk_reg, chk_next;
    logic                op_ins_reg, op_ins_next;
    logic                op_del_reg, op_del_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [COLUMN_W-1:0] col_reg, col_next;
    status_t             status_reg, status_next;
    logic [RW-1:0]       rslot_reg, rslot_next;

    logic [CCW-1:0]      eff_n;
    logic                chk_en;
    logic                match;
    logic                issue_more;
    logic [RW-1:0]       slot_row;
    logic                row_ok;
    logic                upd_ok;
    logic                res_load;

    // Effective column count: zero reads as one, clamp at the row width
    always_comb begin
        if (col_cnt == '0) begin
            eff_n = CCW'(1);
        end else if (32'(col_cnt) > COLS) begin
            eff_n = CCW'(COLS);
        end else begin
            eff_n = CCW'(col_cnt);
        end
    end

    assign chk_en     = !key_col[CFG_W-1] && (32'(key_col[2:0]) < 32'(eff_n));
    assign match      = pend_valid_reg && used_q && chk_reg && (cell_q == cmp_val_reg);
    assign issue_more = issue_reg < hwm_reg;
    assign slot_row   = RW'(slot_reg);
    assign row_ok     = (32'(slot_reg) < ROWS) && used_q && (HW'(slot_row) < hwm_reg);
    assign upd_ok     = row_ok && (32'(col_reg) < 32'(eff_n));
    assign res_load   = (state_reg == SQ_DONE) && out_free;

    assign idle       = (state_reg == SQ_IDLE);
    assign stg_push   = in_acc && (in_kind == KIND_INSERT);
    assign stg_clear  = (state_reg == SQ_INS_KEY);
    assign stg_rd_idx = (state_reg == SQ_INS_KEY) ? CW'(key_col[2:0]) : wcol_reg;

    assign res.load   = res_load;
    assign res.status = status_reg;
    assign res_slot   = rslot_reg;
    assign rows_used  = used_count_reg;

    // Store address and write strobes
    always_comb begin
        mem_row = slot_row;
        mem_col = CW'(col_reg);
        case (state_reg)
            SQ_SCAN: begin
                mem_row = RW'(issue_reg);
                mem_col = scan_col_reg;
            end
            SQ_WRITE: begin
                mem_row = ins_row_reg;
                mem_col = wcol_reg;
            end
            default: begin
                mem_row = slot_row;
                mem_col = CW'(col_reg);
            end
        endcase

        mem_ctl.cell_we    = ((state_reg == SQ_WRITE) &&
                              ((32'(wcol_reg) < 32'(eff_n)) || fresh_reg)) ||
                             ((state_reg == SQ_CHK) && !op_del_reg && upd_ok);
        mem_ctl.used_we    = ((state_reg == SQ_WRITE) && (wcol_reg == '0)) ||
                             ((state_reg == SQ_CHK) && op_del_reg && row_ok);
        mem_ctl.used_wdata = (state_reg == SQ_WRITE);

        // Columns past the live count of a fresh row hold zero
        if (state_reg == SQ_WRITE) begin
            mem_wdata = ((32'(wcol_reg) < 32'(snap_reg)) &&
                         (32'(wcol_reg) < 32'(eff_n))) ? stg_rd_data : '0;
        end else begin
            mem_wdata = cmp_val_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        hwm_next        = hwm_reg;
        used_count_next = used_count_reg;
        pend_valid_next = pend_valid_reg;
        issue_next      = issue_reg;
        pend_row_next   = pend_row_reg;
        free_found_next = free_found_reg;
        free_row_next   = free_row_reg;
        ins_row_next    = ins_row_reg;
        fresh_next      = fresh_reg;
        wcol_next       = wcol_reg;
        scan_col_next   = scan_col_reg;
        snap_next       = snap_reg;
        cmp_val_next    = cmp_val_reg;
        chk_next        = chk_reg;
        op_ins_next     = op_ins_reg;
        op_del_next     = op_del_reg;
        slot_next       = slot_reg;
        col_next        = col_reg;
        status_next     = status_reg;
        rslot_next      = rslot_reg;

        case (state_reg)
            SQ_IDLE: begin
                if (in_acc) begin
                    slot_next       = in_slot;
                    col_next        = in_col;
                    cmp_val_next    = in_val;
                    op_ins_next     = (in_kind == KIND_INSERT);
                    op_del_next     = (in_kind == KIND_DELETE);
                    issue_next      = '0;
                    pend_valid_next = 1'b0;
                    free_found_next = 1'b0;
                    scan_col_next   = '0;
                    chk_next        = 1'b1;
                    case (kind_t'(in_kind))
                        KIND_INSERT: begin
                            if (in_last) begin
                                state_next = SQ_INS_KEY;
                            end
                        end
                        KIND_UPDATE: state_next = SQ_RD;
                        KIND_DELETE: state_next = SQ_RD;
                        KIND_SELECT: state_next = SQ_SCAN;
                        default:     state_next = SQ_IDLE;
                    endcase
                end
            end

            SQ_INS_KEY: begin
                // Freeze the staged run and pick out the key word
                snap_next     = stg_cnt;
                cmp_val_next  = (32'(key_col[2:0]) < 32'(stg_cnt)) ? stg_rd_data : '0;
                chk_next      = chk_en;
                scan_col_next = CW'(key_col[2:0]);
                state_next    = SQ_SCAN;
            end

            SQ_SCAN: begin
                if (match) begin
                    status_next     = op_ins_reg ? STAT_DUP_KEY : STAT_OK;
                    rslot_next      = op_ins_reg ? '0 : pend_row_reg;
                    pend_valid_next = 1'b0;
                    state_next      = SQ_DONE;
                end else begin
                    if (op_ins_reg && pend_valid_reg && !used_q && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_row_next   = pend_row_reg;
                    end
                    if (issue_more) begin
                        issue_next      = issue_reg + HW'(1);
                        pend_valid_next = 1'b1;
                        pend_row_next   = RW'(issue_reg);
                    end else begin
                        pend_valid_next = 1'b0;
                        if (!pend_valid_reg) begin
                            rslot_next = '0;
                            wcol_next  = '0;
                            if (!op_ins_reg) begin
                                status_next = STAT_NOT_FOUND;
                                state_next  = SQ_DONE;
                            end else if (free_found_reg) begin
                                ins_row_next = free_row_reg;
                                fresh_next   = 1'b0;
                                state_next   = SQ_WRITE;
                            end else if (32'(hwm_reg) < ROWS) begin
                                ins_row_next = RW'(hwm_reg);
                                fresh_next   = 1'b1;
                                state_next   = SQ_WRITE;
                            end else begin
                                status_next = STAT_FULL;
                                state_next  = SQ_DONE;
                            end
                        end
                    end
                end
            end

            SQ_WRITE: begin
                wcol_next = wcol_reg + CW'(1);
                if (wcol_reg == CW'(COLS - 1)) begin
                    used_count_next = used_count_reg + HW'(1);
                    if (fresh_reg) begin
                        hwm_next = hwm_reg + HW'(1);
                    end
                    status_next = STAT_OK;
                    rslot_next  = ins_row_reg;
                    state_next  = SQ_DONE;
                end
            end

            SQ_RD: begin
                state_next = SQ_CHK;
            end

            SQ_CHK: begin
                rslot_next = '0;
                if (op_del_reg) begin
                    if (row_ok) begin
                        if (used_count_reg != '0) begin
                            used_count_next = used_count_reg - HW'(1);
                        end
                        status_next = STAT_OK;
                    end else begin
                        status_next = STAT_BAD_SLOT;
                    end
                end else begin
                    status_next = upd_ok ? STAT_OK : STAT_BAD_SLOT;
                end
                state_next = SQ_DONE;
            end

            SQ_DONE: begin
                if (out_free) begin
                    state_next = SQ_IDLE;
                end
            end

            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SQ_IDLE;
            hwm_reg        <= '0;
            used_count_reg <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hwm_reg        <= hwm_next;
            used_count_reg <= used_count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg      <= issue_next;
        pend_row_reg   <= pend_row_next;
        free_found_reg <= free_found_next;
        free_row_reg   <= free_row_next;
        ins_row_reg    <= ins_row_next;
        fresh_reg      <= fresh_next;
        wcol_reg       <= wcol_next;
        scan_col_reg   <= scan_col_next;
        snap_reg       <= snap_next;
        cmp_val_reg    <= cmp_val_next;
        chk_reg        <= chk_next;
        op_ins_reg     <= op_ins_next;
        op_del_reg     <= op_del_next;
        slot_reg       <= slot_next;
        col_reg        <= col_next;
        status_reg     <= status_next;
        rslot_reg      <= rslot_next;
    end

    a_count_le_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= hwm_reg)
        else $error("used row count above fill mark");

    a_hwm_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(hwm_reg) <= ROWS)
        else $error("fill mark beyond table depth");

    a_pend_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_SCAN) && pend_valid_reg |-> HW'(pend_row_reg) < hwm_reg)
        else $error("scan compares a row never written");

    a_load_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |=> state_reg == SQ_IDLE)
        else $error("sequencer did not return to idle after result");

endmodule

[rtl/core/unique_key_row_table_core.sv]
// Top level of the unique-key row table: ports, configuration and output register.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tdata slot,column,cell_value; tuser kind; tlast
//  m_      | out       | m_tvalid/m_tready  | tdata status,result_slot,rows_used
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
//  Steps: a non-final insert word is only staged. Update and delete do one store read,
//  then one check. Select scans the rows below hwm, stopping early on a match, and a
//  final insert word scans them too, then writes the row; hwm is the fill mark (rows
//  ever inserted), and the scan runs through the single-port row store at one row a
//  cycle.
//  Reset: control state clears at once; the store needs no clearing pass, since rows
//  at or above the fill mark read as unused and a fresh row is written in full.
//  Stalls: the result waits in the output register while the next word is taken;
//  a further result holds the sequencer until the output register is free.
module unique_key_row_table_core
    import utbl_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [5:0] slot, [8:6] column, [40:9] cell_value
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] kind
    input  logic                 s_tlast,   // last word of an insert run
    // Result words
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] status, [8:3] result_slot, [15:9] rows_used
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int RW  = $clog2(ROWS);
    localparam int CW  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CCW = $clog2(COLS + 1);
    localparam int HW  = $clog2(ROWS + 1);

    logic                 in_acc;
    logic                 seq_idle;
    logic                 out_free;

    logic [CFG_W-1:0]     key_col_reg;
    logic [CFG_W-1:0]     col_cnt_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [CCW-1:0]       stg_cnt;
    logic [VALUE_W-1:0]   stg_rd_data;
    logic [CW-1:0]        stg_rd_idx;
    logic                 stg_push;
    logic                 stg_clear;

    logic [RW-1:0]        mem_row;
    logic [CW-1:0]        mem_col;
    mem_ctl_t             mem_ctl;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [VALUE_W-1:0]   cell_q;
    logic                 used_q;

    res_t                 res;
    logic [RW-1:0]        res_slot;
    logic [HW-1:0]        rows_used;

    // Take words only while the sequencer is free
    assign s_tready = seq_idle;
    assign in_acc   = s_tvalid && seq_idle;
    assign out_free = !m_tvalid_reg || m_tready;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_col_reg <= '0;
            col_cnt_reg <= CFG_W'(3);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY_COLUMN:   key_col_reg <= cfg_data;
                CFG_COLUMN_COUNT: col_cnt_reg <= cfg_data;
                default:          key_col_reg <= key_col_reg;
            endcase
        end
    end

    utbl_stage #(
        .COLS (COLS)
    ) u_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (stg_push),
        .push_data (s_tdata[40:9]),
        .clear     (stg_clear),
        .rd_idx    (stg_rd_idx),
        .rd_data   (stg_rd_data),
        .cnt       (stg_cnt)
    );

    utbl_store #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_store (
        .aclk   (aclk),
        .row    (mem_row),
        .col    (mem_col),
        .ctl    (mem_ctl),
        .wdata  (mem_wdata),
        .cell_q (cell_q),
        .used_q (used_q)
    );

    utbl_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_acc      (in_acc),
        .in_kind     (s_tuser),
        .in_slot     (s_tdata[5:0]),
        .in_col      (s_tdata[8:6]),
        .in_val      (s_tdata[40:9]),
        .in_last     (s_tlast),
        .key_col     (key_col_reg),
        .col_cnt     (col_cnt_reg),
        .out_free    (out_free),
        .idle        (seq_idle),
        .stg_cnt     (stg_cnt),
        .stg_rd_data (stg_rd_data),
        .stg_rd_idx  (stg_rd_idx),
        .stg_push    (stg_push),
        .stg_clear   (stg_clear),
        .mem_row     (mem_row),
        .mem_col     (mem_col),
        .mem_ctl     (mem_ctl),
        .mem_wdata   (mem_wdata),
        .cell_q      (cell_q),
        .used_q      (used_q),
        .res         (res),
        .res_slot    (res_slot),
        .rows_used   (rows_used)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_tdata_reg <= {ROWS_W'(rows_used), SLOT_W'(res_slot), res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
